// ----- rtl/utf8_decoder_byte_fallback_assert.svh -----
// Assertion macros shared by the decoder modules.
`ifndef UTF8_DECODER_BYTE_FALLBACK_ASSERT_SVH
`define UTF8_DECODER_BYTE_FALLBACK_ASSERT_SVH

// Hold a condition on every clock edge outside reset.
`define U8D_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Hold a consequent in the same cycle as its trigger.
`define U8D_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication failed");

// Hold a consequent in the cycle after its trigger.
`define U8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/u8dec_pkg.sv -----
// Shared types and constants of the UTF-8 decoder with byte fallback.
package u8dec_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int RUN_MAX  = 4;
    localparam int RUN_CW   = 3;
    localparam int RUN_IW   = 2;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] L2_MASK   = 8'hE0;
    localparam logic [BYTE_W-1:0] L2_TAG    = 8'hC0;
    localparam logic [BYTE_W-1:0] L3_MASK   = 8'hF0;
    localparam logic [BYTE_W-1:0] L3_TAG    = 8'hE0;
    localparam logic [BYTE_W-1:0] L4_MASK   = 8'hF8;
    localparam logic [BYTE_W-1:0] L4_TAG    = 8'hF0;
    localparam logic [BYTE_W-1:0] PAY_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] L2_BITS   = 8'h1F;
    localparam logic [BYTE_W-1:0] L3_BITS   = 8'h0F;
    localparam logic [BYTE_W-1:0] L4_BITS   = 8'h07;

    // One byte's worth of results, handed from the decoder to the result buffer.
    typedef struct packed {
        logic [RUN_CW-1:0]             count;
        logic [RUN_MAX-1:0][CP_W-1:0]  vals;
    } t_run;

endpackage

// ----- rtl/u8dec_core.sv -----
// Input register, sequence state and single-pass decode of one byte.
module u8dec_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [u8dec_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                          i_end_of_text,
    output logic                          o_run_valid,
    output u8dec_pkg::t_run               o_run,
    input  logic                          i_load_ok
);
    import u8dec_pkg::*;

    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic                 r_in_eot;

    logic [BYTE_W-1:0]    r_lead,  n_lead;
    logic [BYTE_W-1:0]    r_pend [2];
    logic [BYTE_W-1:0]    n_pend [2];
    logic [2:0]           r_need,  n_need;
    logic [1:0]           r_rc,    n_rc;
    logic [CP_W-1:0]      r_part,  n_part;

    logic [RUN_CW-1:0]            cnt;
    logic [RUN_MAX-1:0][CP_W-1:0] vals;
    logic [CP_W-1:0]              cont_val;
    logic [2:0]                   lead_len;
    logic [CP_W-1:0]              lead_bits;
    logic                         adv;

    // Classify the byte as a lead: length of its form, 0 when it stands alone.
    always_comb begin
        lead_len  = 3'd0;
        lead_bits = '0;
        priority if ((r_in_byte & L2_MASK) == L2_TAG) begin
            lead_len  = 3'd2;
            lead_bits = {{(CP_W-BYTE_W){1'b0}}, r_in_byte & L2_BITS};
        end else if ((r_in_byte & L3_MASK) == L3_TAG) begin
            lead_len  = 3'd3;
            lead_bits = {{(CP_W-BYTE_W){1'b0}}, r_in_byte & L3_BITS};
        end else if ((r_in_byte & L4_MASK) == L4_TAG) begin
            lead_len  = 3'd4;
            lead_bits = {{(CP_W-BYTE_W){1'b0}}, r_in_byte & L4_BITS};
        end else begin
            lead_len  = 3'd0;
            lead_bits = '0;
        end
    end

    assign cont_val = {r_part[CP_W-7:0], r_in_byte[5:0]};

    always_comb begin
        n_lead    = r_lead;
        n_pend[0] = r_pend[0];
        n_pend[1] = r_pend[1];
        n_need    = r_need;
        n_rc      = r_rc;
        n_part    = r_part;
        vals      = '0;
        cnt       = '0;

        if (r_need != 3'd0 && (r_in_byte & CONT_MASK) == CONT_TAG) begin
            if ({1'b0, r_rc} + 3'd2 >= r_need) begin
                vals[cnt[RUN_IW-1:0]] = cont_val;
                cnt    = cnt + 3'd1;
                n_need = 3'd0;
                n_rc   = 2'd0;
                n_part = '0;
            end else begin
                if (!r_rc[1]) begin
                    n_pend[r_rc[0]] = r_in_byte;
                end
                n_rc   = r_rc + 2'd1;
                n_part = cont_val;
            end
        end else begin
            // Broken sequence, if any: drop it out raw, then start afresh on this byte.
            if (r_need != 3'd0) begin
                vals[cnt[RUN_IW-1:0]] = {{(CP_W-BYTE_W){1'b0}}, r_lead};
                cnt = cnt + 3'd1;
                if (r_rc != 2'd0) begin
                    vals[cnt[RUN_IW-1:0]] = {{(CP_W-BYTE_W){1'b0}}, r_pend[0]};
                    cnt = cnt + 3'd1;
                end
                if (r_rc[1]) begin
                    vals[cnt[RUN_IW-1:0]] = {{(CP_W-BYTE_W){1'b0}}, r_pend[1]};
                    cnt = cnt + 3'd1;
                end
                n_need = 3'd0;
                n_rc   = 2'd0;
                n_part = '0;
            end
            if (lead_len == 3'd0) begin
                vals[cnt[RUN_IW-1:0]] = {{(CP_W-BYTE_W){1'b0}}, r_in_byte};
                cnt = cnt + 3'd1;
            end else begin
                n_lead = r_in_byte;
                n_need = lead_len;
                n_rc   = 2'd0;
                n_part = lead_bits;
            end
        end

        // End of text: flush whatever sequence is still open.
        if (r_in_eot && n_need != 3'd0) begin
            vals[cnt[RUN_IW-1:0]] = {{(CP_W-BYTE_W){1'b0}}, n_lead};
            cnt = cnt + 3'd1;
            if (n_rc != 2'd0) begin
                vals[cnt[RUN_IW-1:0]] = {{(CP_W-BYTE_W){1'b0}}, n_pend[0]};
                cnt = cnt + 3'd1;
            end
            if (n_rc[1]) begin
                vals[cnt[RUN_IW-1:0]] = {{(CP_W-BYTE_W){1'b0}}, n_pend[1]};
                cnt = cnt + 3'd1;
            end
            n_need = 3'd0;
            n_rc   = 2'd0;
            n_part = '0;
        end
    end

    assign adv         = r_in_valid && (cnt == '0 || i_load_ok);
    assign o_stall     = r_in_valid && !adv;
    assign o_run_valid = r_in_valid && cnt != '0;
    assign o_run.count = cnt;
    assign o_run.vals  = vals;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_need <= 3'd0;
            r_rc   <= 2'd0;
            r_part <= '0;
        end else if (adv) begin
            r_lead <= n_lead;
            r_need <= n_need;
            r_rc   <= n_rc;
            r_part <= n_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pend[0] <= n_pend[0];
            r_pend[1] <= n_pend[1];
        end
    end

`include "utf8_decoder_byte_fallback_assert.svh"

    `U8D_ASSERT_ALWAYS(a_need_legal, i_clk, i_rst_n, r_need != 3'd1 && r_need <= 3'd4, "bad form length")
    `U8D_ASSERT_IMPLIES(a_rc_closed, i_clk, i_rst_n, r_need == 3'd0 || r_rc == 2'd3, r_rc == 2'd0)
    `U8D_ASSERT_NEXT(a_eot_closes, i_clk, i_rst_n, adv && r_in_eot, r_need == 3'd0)

endmodule

// ----- rtl/u8dec_outbuf.sv -----
// Result register: holds one byte's run and hands it out one beat at a time.
module u8dec_outbuf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_run_valid,
    input  u8dec_pkg::t_run             i_run,
    output logic                        o_load_ok,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [u8dec_pkg::CP_W-1:0]  o_code_point,
    output logic                        o_run_last
);
    import u8dec_pkg::*;

    logic [RUN_MAX-1:0][CP_W-1:0] r_vals;
    logic [RUN_CW-1:0]            r_left;
    logic [RUN_IW-1:0]            r_idx;
    logic                         pop;
    logic                         load;

    assign o_valid      = r_left != '0;
    assign pop          = o_valid && !i_stall;
    assign o_load_ok    = r_left == '0 || (pop && r_left == 3'd1);
    assign load         = i_run_valid && o_load_ok;
    assign o_code_point = r_vals[r_idx];
    assign o_run_last   = r_left == 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (load) begin
            r_left <= i_run.count;
            r_idx  <= '0;
        end else if (pop) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vals <= i_run.vals;
        end
    end

`include "utf8_decoder_byte_fallback_assert.svh"

    `U8D_ASSERT_ALWAYS(a_left_max, i_clk, i_rst_n, r_left <= 3'd4, "run count overflow")
    `U8D_ASSERT_NEXT(a_run_restart, i_clk, i_rst_n, load, r_idx == 2'd0)
    `U8D_ASSERT_NEXT(a_run_cont, i_clk, i_rst_n, pop && r_left > 3'd1, o_valid)

endmodule

// ----- rtl/utf8_decoder_byte_fallback.sv -----
// Top level of the UTF-8 decoder with per-byte raw fallback.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  -------------------------------
//  byte in   input      i_valid / o_stall    i_data_byte, i_end_of_text
//  cp out    output     o_valid / i_stall    o_code_point, o_run_last
//
// A byte is registered on entry and decoded in one pass the next cycle; its
// run of 0 to 4 code points lands in the result register, which releases one
// beat per cycle while unstalled; bytes giving at most one beat flow at one
// per cycle likewise. A longer run holds the input until its last beat leaves
// the single output port. Reset (synchronous, active low) closes any open
// sequence and empties both registers. Bytes that emit nothing advance without
// touching the result register; downstream stall freezes the current beat.
module utf8_decoder_byte_fallback (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [u8dec_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                          i_end_of_text,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [u8dec_pkg::CP_W-1:0]    o_code_point,
    output logic                          o_run_last
);
    import u8dec_pkg::*;

    t_run  run;
    logic  run_valid;
    logic  load_ok;

    // Decode stage: input register plus sequence state.
    u8dec_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_run_valid   (run_valid),
        .o_run         (run),
        .i_load_ok     (load_ok)
    );

    // Result register: serialises each run onto the output channel.
    u8dec_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run_valid  (run_valid),
        .i_run        (run),
        .o_load_ok    (load_ok),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_point (o_code_point),
        .o_run_last   (o_run_last)
    );

endmodule
